/* src/ordered_list_insert_remove_assert.svh */
// Assertion macros for the ordered list block.
// Each macro takes a label, the clock, the active-low reset, a trigger and a consequence.
`ifndef ORDERED_LIST_INSERT_REMOVE_ASSERT_SVH
`define ORDERED_LIST_INSERT_REMOVE_ASSERT_SVH

`ifndef SYNTHESIS

// Consequence holds in the same cycle as the trigger.
`define OLIR_ASSERT_SAME(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("assertion failed");

// Consequence holds in the cycle after the trigger.
`define OLIR_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`else

`define OLIR_ASSERT_SAME(label, clk, rst_n, trig, cons)
`define OLIR_ASSERT_NEXT(label, clk, rst_n, trig, cons)

`endif

`endif

/* src/olir_pkg.sv */
`timescale 1ns / 1ps

package olir_pkg;

  // List geometry
  localparam int CAPACITY   = 64;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int FUNC_W     = 3;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [FUNC_W-1:0]     func_t;

  // Operation codes
  localparam func_t F_GET    = 3'd0;
  localparam func_t F_SET    = 3'd1;
  localparam func_t F_APPEND = 3'd2;
  localparam func_t F_INSERT = 3'd3;
  localparam func_t F_POP    = 3'd4;
  localparam func_t F_REMOVE = 3'd5;
  localparam func_t F_CLEAR  = 3'd6;

endpackage

/* src/olir_ram.sv */
`timescale 1ns / 1ps

module olir_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  // Write one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

/* src/ordered_list_insert_remove.sv */
`timescale 1ns / 1ps
// Ordered list of up to 64 words of 32 bits with an occupancy count.
// Issue a request by raising start with in_func, in_index and in_value; the word
// is taken at a rising edge where start is high and busy is low. Every request
// answers with exactly one result: out_strobe is high for one cycle with
// out_read_value, out_ok and out_count. The receiver cannot stall; it must take
// the result in that cycle.
// Path from accept to strobe:
//   set, append, clear, rejected: result in the cycle after accept (busy stays low)
//   get, pop: through the registered memory read, S_RUN and the output register
//   remove, insert: S_RUN walks index to last entry; insert then writes in S_FIN
// Insert and remove stream the shifted entries through the single-port-pair
// entry RAM, one read and one write per cycle. A new request may be accepted
// in the cycle the result of the previous one is shown.
// Reset empties the list at once; entry contents are not cleared, and clear
// only drops the count, since entries at or above the count are never read.
module ordered_list_insert_remove (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  olir_pkg::func_t        in_func,
  input  olir_pkg::idx_t         in_index,
  input  olir_pkg::word_t        in_value,
  output logic                   out_strobe,
  output olir_pkg::word_t        out_read_value,
  output logic                   out_ok,
  output olir_pkg::cnt_t         out_count
);
  import olir_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam cnt_t CAP_C = CNT_W'(CAPACITY);

  logic [1:0] st_r, st_nxt;
  func_t      op_r, op_nxt;
  idx_t       idx_r, idx_nxt;
  word_t      val_r, val_nxt;
  cnt_t       cnt_r, cnt_nxt;
  idx_t       rp_r, rp_nxt;
  idx_t       pa_r, pa_nxt;
  logic       more_r, more_nxt;
  word_t      rdv_r, rdv_nxt;

  logic       out_strobe_r;
  word_t      out_rd_r;
  logic       out_ok_r;
  cnt_t       out_cnt_r;

  logic       emit;
  word_t      e_rd;
  logic       e_ok;
  cnt_t       e_cnt;

  logic       mem_we, mem_re;
  idx_t       mem_wa, mem_ra;
  word_t      mem_wd, mem_rd;

  logic       in_rng;
  logic       not_full;
  cnt_t       cnt_m1;
  cnt_t       rp_inc;

  olir_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_WIDTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .re  (mem_re),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

  assign in_rng   = {1'b0, in_index} < cnt_r;
  assign not_full = cnt_r < CAP_C;
  assign cnt_m1   = cnt_r - 1'b1;
  assign rp_inc   = {1'b0, rp_r} + 1'b1;

  // Sequence requests and the shift stream
  always_comb begin
    st_nxt   = st_r;
    op_nxt   = op_r;
    idx_nxt  = idx_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    rp_nxt   = rp_r;
    pa_nxt   = pa_r;
    more_nxt = more_r;
    rdv_nxt  = rdv_r;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;
    mem_re   = 1'b0;
    mem_ra   = '0;
    emit     = 1'b0;
    e_rd     = '0;
    e_ok     = 1'b0;
    e_cnt    = cnt_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_func;
          idx_nxt = in_index;
          val_nxt = in_value;
          case (in_func)
            F_GET: begin
              if (in_rng) begin
                mem_re = 1'b1;
                mem_ra = in_index;
                st_nxt = S_RUN;
              end else begin
                emit = 1'b1;
              end
            end
            F_SET: begin
              emit = 1'b1;
              if (in_rng) begin
                mem_we = 1'b1;
                mem_wa = in_index;
                mem_wd = in_value;
                e_ok   = 1'b1;
              end
            end
            F_APPEND: begin
              emit = 1'b1;
              if (not_full) begin
                mem_we  = 1'b1;
                mem_wa  = cnt_r[IDX_W-1:0];
                mem_wd  = in_value;
                cnt_nxt = cnt_r + 1'b1;
                e_cnt   = cnt_nxt;
                e_ok    = 1'b1;
              end
            end
            F_INSERT: begin
              if (in_rng && not_full) begin
                // Walk down from the last entry
                mem_re   = 1'b1;
                mem_ra   = cnt_m1[IDX_W-1:0];
                pa_nxt   = cnt_m1[IDX_W-1:0];
                rp_nxt   = cnt_m1[IDX_W-1:0] - 1'b1;
                more_nxt = cnt_m1[IDX_W-1:0] != in_index;
                st_nxt   = S_RUN;
              end else begin
                emit = 1'b1;
              end
            end
            F_POP: begin
              if (cnt_r != '0) begin
                mem_re = 1'b1;
                mem_ra = cnt_m1[IDX_W-1:0];
                st_nxt = S_RUN;
              end else begin
                emit = 1'b1;
              end
            end
            F_REMOVE: begin
              if (in_rng) begin
                // Walk up from the removed entry
                mem_re   = 1'b1;
                mem_ra   = in_index;
                pa_nxt   = in_index;
                rp_nxt   = in_index + 1'b1;
                more_nxt = ({1'b0, in_index} + 1'b1) < cnt_r;
                st_nxt   = S_RUN;
              end else begin
                emit = 1'b1;
              end
            end
            F_CLEAR: begin
              emit    = 1'b1;
              e_ok    = 1'b1;
              cnt_nxt = '0;
              e_cnt   = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_RUN: begin
        case (op_r)
          F_GET: begin
            emit   = 1'b1;
            e_ok   = 1'b1;
            e_rd   = mem_rd;
            st_nxt = S_IDLE;
          end
          F_POP: begin
            emit    = 1'b1;
            e_ok    = 1'b1;
            e_rd    = mem_rd;
            cnt_nxt = cnt_m1;
            e_cnt   = cnt_m1;
            st_nxt  = S_IDLE;
          end
          F_REMOVE: begin
            // Keep the removed word, move every later word down one place
            if (pa_r == idx_r) begin
              rdv_nxt = mem_rd;
            end else begin
              mem_we = 1'b1;
              mem_wa = pa_r - 1'b1;
              mem_wd = mem_rd;
            end
            if (more_r) begin
              mem_re   = 1'b1;
              mem_ra   = rp_r;
              pa_nxt   = rp_r;
              rp_nxt   = rp_r + 1'b1;
              more_nxt = rp_inc < cnt_r;
            end else begin
              emit    = 1'b1;
              e_ok    = 1'b1;
              e_rd    = (pa_r == idx_r) ? mem_rd : rdv_r;
              cnt_nxt = cnt_m1;
              e_cnt   = cnt_m1;
              st_nxt  = S_IDLE;
            end
          end
          F_INSERT: begin
            // Move every word from the index up one place
            mem_we = 1'b1;
            mem_wa = pa_r + 1'b1;
            mem_wd = mem_rd;
            if (more_r) begin
              mem_re   = 1'b1;
              mem_ra   = rp_r;
              pa_nxt   = rp_r;
              rp_nxt   = rp_r - 1'b1;
              more_nxt = rp_r != idx_r;
            end else begin
              st_nxt = S_FIN;
            end
          end
          default: begin
            st_nxt = S_IDLE;
          end
        endcase
      end
      S_FIN: begin
        // Drop the new word into the opened slot
        mem_we  = 1'b1;
        mem_wa  = idx_r;
        mem_wd  = val_r;
        cnt_nxt = cnt_r + 1'b1;
        e_cnt   = cnt_nxt;
        emit    = 1'b1;
        e_ok    = 1'b1;
        st_nxt  = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= emit;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    rp_r    <= rp_nxt;
    pa_r    <= pa_nxt;
    more_r  <= more_nxt;
    rdv_r   <= rdv_nxt;
    if (emit) begin
      out_rd_r  <= e_rd;
      out_ok_r  <= e_ok;
      out_cnt_r <= e_cnt;
    end
  end

  assign busy           = st_r != S_IDLE;
  assign out_strobe     = out_strobe_r;
  assign out_read_value = out_rd_r;
  assign out_ok         = out_ok_r;
  assign out_count      = out_cnt_r;

  `include "ordered_list_insert_remove_assert.svh"

  `OLIR_ASSERT_NEXT(a_accept_answers, clk, rst_n, start && !busy, busy || out_strobe)
  `OLIR_ASSERT_SAME(a_reject_zero, clk, rst_n, out_strobe && !out_ok, out_read_value == '0)
  `OLIR_ASSERT_SAME(a_write_in_list, clk, rst_n, mem_we, {1'b0, mem_wa} <= cnt_r)

endmodule
